>>> src/grid_cell_binning_assert.svh
// ---------------------------------------------------------------------------
// grid_cell_binning assertion macros
// concurrent checks on aclk, held off while aresetn is low
// ---------------------------------------------------------------------------
`ifndef GRID_CELL_BINNING_ASSERT_SVH
`define GRID_CELL_BINNING_ASSERT_SVH
`ifndef SYNTHESIS
`define GCB_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("grid_cell_binning: check failed");
`define GCB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("grid_cell_binning: check failed");
`else
`define GCB_ASSERT_IMPL(label, ante, cons)
`define GCB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> src/gcb_pkg.sv
// ---------------------------------------------------------------------------
// gcb_pkg
// shared types and constants of the grid cell binning pipeline
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gcb_pkg;

    // configuration register indexes
    localparam logic CFG_LEVEL_WIDTH  = 1'b0;
    localparam logic CFG_LEVEL_HEIGHT = 1'b1;

    localparam logic [15:0] LEVEL_SIZE_RESET = 16'd1024;

    // which corners of the box land in distinct cells
    typedef enum logic [1:0] {
        RUN_ONE,
        RUN_ROWS,
        RUN_COLS,
        RUN_FOUR
    } run_kind_t;

    typedef struct packed {
        logic [15:0]        tag;
        logic signed [15:0] box_x;
        logic signed [15:0] box_y;
        logic [14:0]        box_w;
        logic [14:0]        box_h;
    } box_item_t;

    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] x1;
        logic [15:0] x2;
        logic [15:0] y1;
        logic [15:0] y2;
    } corner_t;

    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] c1;
        logic [15:0] c2;
        logic [15:0] r1;
        logic [15:0] r2;
    } cellpos_t;

    typedef struct packed {
        logic [15:0] tag;
        run_kind_t   kind;
        logic [15:0] c1;
        logic [15:0] c2;
        logic [19:0] base1;
        logic [19:0] base2;
    } rowbase_t;

endpackage

`default_nettype wire

>>> src/grid_cell_binning.sv
// ---------------------------------------------------------------------------
// grid_cell_binning
// bins one object's bounding box into the cells of a uniform square grid
// ---------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata: tag, box x/y, box width/height
//  m_        out  m_tvalid/m_tready  m_tdata: tag, cell index; m_tlast
//  cfg_      in   cfg_wr_en          cfg_addr, cfg_wdata (no read-back)
//
//  five register stages: input, clamp, cell map, row base, output
//  one object enters per cycle while the output register is free; it yields
//  1, 2 or 4 cells at one per cycle while m_tready is high, and the output
//  register takes the next object only when the last cell of a run moves out
//  reset clears stage valid bits and sets both level sizes to 1024
//  a stall on m_tready holds the whole pipeline, bubbles included
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "grid_cell_binning_assert.svh"

module grid_cell_binning
    import gcb_pkg::*;
#(
    parameter int CELL_SIZE = 64,
    parameter int MARGIN    = 10
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] item_tag, [31:16] box_x, [47:32] box_y, [62:48] box_width,
    // [77:63] box_height, zero pad
    input  wire logic [79:0] s_tdata,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [15:0] tag_out, [35:16] cell_index, zero pad
    output logic             m_tlast,   // last_cell

    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_addr,
    input  wire logic [15:0] cfg_wdata
);

    logic [15:0] level_width_reg, level_height_reg;
    logic        in_valid_reg;
    box_item_t   in_item_reg;
    logic        adv;

    logic        clamp_valid;
    corner_t     clamp_corner;
    logic        map_valid;
    cellpos_t    map_pos;
    logic [15:0] cols;
    logic        idx_valid;
    rowbase_t    idx_base;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_width_reg  <= LEVEL_SIZE_RESET;
            level_height_reg <= LEVEL_SIZE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_LEVEL_WIDTH:  level_width_reg  <= cfg_wdata;
                CFG_LEVEL_HEIGHT: level_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_item_reg.tag   <= s_tdata[15:0];
            in_item_reg.box_x <= s_tdata[31:16];
            in_item_reg.box_y <= s_tdata[47:32];
            in_item_reg.box_w <= s_tdata[62:48];
            in_item_reg.box_h <= s_tdata[77:63];
        end
    end

    gcb_clamp #(
        .MARGIN (MARGIN)
    ) u_clamp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (adv),
        .in_valid     (in_valid_reg),
        .in_item      (in_item_reg),
        .level_width  (level_width_reg),
        .level_height (level_height_reg),
        .out_valid    (clamp_valid),
        .out_corner   (clamp_corner)
    );

    gcb_cellmap #(
        .CELL_SIZE (CELL_SIZE)
    ) u_cellmap (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (adv),
        .in_valid    (clamp_valid),
        .in_corner   (clamp_corner),
        .level_width (level_width_reg),
        .out_valid   (map_valid),
        .out_pos     (map_pos),
        .cols        (cols)
    );

    gcb_index u_index (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (map_valid),
        .in_pos    (map_pos),
        .cols      (cols),
        .out_valid (idx_valid),
        .out_base  (idx_base)
    );

    gcb_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (idx_valid),
        .in_base  (idx_base),
        .ready    (adv),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // a run never breaks off before its last cell
    `GCB_ASSERT_NEXT(a_run_continues, m_tvalid && m_tready && !m_tlast, m_tvalid)
    // every cell of a run carries the same tag
    `GCB_ASSERT_NEXT(a_run_tag_held, m_tvalid && m_tready && !m_tlast, m_tdata[15:0] == $past(m_tdata[15:0]))
    // an empty output register never holds back the input side
    `GCB_ASSERT_IMPL(a_ready_when_empty, !m_tvalid, s_tready)

endmodule

`default_nettype wire

>>> src/gcb_clamp.sv
// ---------------------------------------------------------------------------
// gcb_clamp
// widens the box by the margin and clamps each corner into the level
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gcb_clamp
    import gcb_pkg::*;
#(
    parameter int MARGIN = 10
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire box_item_t   in_item,
    input  wire logic [15:0] level_width,
    input  wire logic [15:0] level_height,
    output logic             out_valid,
    output corner_t          out_corner
);

    // room for a 16 bit signed edge plus a 15 bit extent plus the margin
    localparam int COORD_W = 18;
    localparam logic signed [COORD_W-1:0] MARG = COORD_W'(MARGIN);

    function automatic logic [15:0] clamp_to(input logic signed [COORD_W-1:0] v,
                                             input logic [15:0] size);
        logic [15:0]                hi;
        logic signed [COORD_W-1:0]  hi_s;
        hi   = (size == 16'd0) ? 16'd0 : size - 16'd1;
        hi_s = signed'(COORD_W'(hi));
        if (v < 0) begin
            return 16'd0;
        end
        if (v > hi_s) begin
            return hi;
        end
        return v[15:0];
    endfunction

    logic signed [COORD_W-1:0] bx_e, by_e, bw_e, bh_e;
    corner_t corner_next;
    logic    valid_reg;
    corner_t corner_reg;

    always_comb begin
        bx_e = COORD_W'(in_item.box_x);
        by_e = COORD_W'(in_item.box_y);
        bw_e = signed'(COORD_W'(in_item.box_w));
        bh_e = signed'(COORD_W'(in_item.box_h));
        corner_next.tag = in_item.tag;
        corner_next.x1  = clamp_to(bx_e - MARG, level_width);
        corner_next.x2  = clamp_to(bx_e + bw_e + MARG, level_width);
        corner_next.y1  = clamp_to(by_e - MARG, level_height);
        corner_next.y2  = clamp_to(by_e + bh_e + MARG, level_height);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            corner_reg <= corner_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_corner = corner_reg;

endmodule

`default_nettype wire

>>> src/gcb_cellmap.sv
// ---------------------------------------------------------------------------
// gcb_cellmap
// maps clamped corners to grid columns and rows, and the level width to
// the column count, by multiplying with the reciprocal of the cell size
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gcb_cellmap
    import gcb_pkg::*;
#(
    parameter int CELL_SIZE = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire corner_t     in_corner,
    input  wire logic [15:0] level_width,
    output logic             out_valid,
    output cellpos_t         out_pos,
    output logic [15:0]      cols
);

    // ceil(2^32 / CELL_SIZE): exact quotient for any 17 bit dividend
    localparam logic [32:0] RECIP =
        33'(((64'd1 << 32) + 64'(CELL_SIZE) - 64'd1) / 64'(CELL_SIZE));

    function automatic logic [15:0] div_cell(input logic [16:0] x);
        logic [49:0] p;
        p = 50'(x) * 50'(RECIP);
        return p[47:32];
    endfunction

    logic [15:0] wmin;
    logic [16:0] wsum;
    logic [15:0] cols_next;
    logic [15:0] cols_reg;
    cellpos_t    pos_next;
    cellpos_t    pos_reg;
    logic        valid_reg;

    always_comb begin
        // a zero width acts as one
        wmin      = (level_width == 16'd0) ? 16'd1 : level_width;
        wsum      = 17'(wmin) + 17'(CELL_SIZE - 1);
        cols_next = div_cell(wsum);

        pos_next.tag = in_corner.tag;
        pos_next.c1  = div_cell(17'(in_corner.x1));
        pos_next.c2  = div_cell(17'(in_corner.x2));
        pos_next.r1  = div_cell(17'(in_corner.y1));
        pos_next.r2  = div_cell(17'(in_corner.y2));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // column count follows the width register in the next cycle
    always_ff @(posedge aclk) begin
        cols_reg <= cols_next;
        if (en) begin
            pos_reg <= pos_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pos   = pos_reg;
    assign cols      = cols_reg;

endmodule

`default_nettype wire

>>> src/gcb_index.sv
// ---------------------------------------------------------------------------
// gcb_index
// row bases of the top and bottom cell rows and the kind of cell run
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gcb_index
    import gcb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        en,
    input  wire logic        in_valid,
    input  wire cellpos_t    in_pos,
    input  wire logic [15:0] cols,
    output logic             out_valid,
    output rowbase_t         out_base
);

    logic [31:0] prod1, prod2;
    logic        same_col, same_row;
    rowbase_t    base_next;
    rowbase_t    base_reg;
    logic        valid_reg;

    always_comb begin
        prod1    = 32'(in_pos.r1) * 32'(cols);
        prod2    = 32'(in_pos.r2) * 32'(cols);
        // column below cols, so equal indexes mean equal rows and columns
        same_col = (in_pos.c1 == in_pos.c2);
        same_row = (in_pos.r1 == in_pos.r2);

        base_next.tag   = in_pos.tag;
        base_next.c1    = in_pos.c1;
        base_next.c2    = in_pos.c2;
        base_next.base1 = prod1[19:0];
        base_next.base2 = prod2[19:0];
        if (same_col && same_row) begin
            base_next.kind = RUN_ONE;
        end else if (same_col) begin
            base_next.kind = RUN_ROWS;
        end else if (same_row) begin
            base_next.kind = RUN_COLS;
        end else begin
            base_next.kind = RUN_FOUR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            base_reg <= base_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_base  = base_reg;

endmodule

`default_nettype wire

>>> src/gcb_emit.sv
// ---------------------------------------------------------------------------
// gcb_emit
// output register: loads the cell run of one object and shifts it out one
// cell per transfer, marking the final cell
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gcb_emit
    import gcb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    input  wire rowbase_t    in_base,
    output logic             ready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [15:0] tag_out, [35:16] cell_index, zero pad
    output logic             m_tlast    // last_cell
);

    logic        valid_reg, valid_next;
    logic [15:0] tag_reg, tag_next;
    logic [19:0] slot_reg [4];
    logic [19:0] slot_next [4];
    logic [1:0]  rem_reg, rem_next;
    logic [19:0] a0, a1, a2, a3;
    logic        xfer, done;

    assign xfer  = valid_reg && m_tready;
    assign done  = !valid_reg || (xfer && (rem_reg == 2'd0));
    assign ready = done;

    always_comb begin
        a0 = in_base.base1 + 20'(in_base.c1);
        a1 = in_base.base1 + 20'(in_base.c2);
        a2 = in_base.base2 + 20'(in_base.c1);
        a3 = in_base.base2 + 20'(in_base.c2);

        valid_next = valid_reg;
        tag_next   = tag_reg;
        rem_next   = rem_reg;
        for (int i = 0; i < 4; i++) begin
            slot_next[i] = slot_reg[i];
        end

        if (done) begin
            valid_next   = in_valid;
            tag_next     = in_base.tag;
            slot_next[0] = a0;
            case (in_base.kind)
                RUN_ONE: begin
                    rem_next = 2'd0;
                end
                RUN_ROWS: begin
                    slot_next[1] = a2;
                    rem_next     = 2'd1;
                end
                RUN_COLS: begin
                    slot_next[1] = a1;
                    rem_next     = 2'd1;
                end
                default: begin
                    // all four corners in distinct cells
                    slot_next[1] = a1;
                    slot_next[2] = a2;
                    slot_next[3] = a3;
                    rem_next     = 2'd3;
                end
            endcase
        end else if (xfer) begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            slot_next[2] = slot_reg[3];
            rem_next     = rem_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            rem_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        tag_reg <= tag_next;
        for (int i = 0; i < 4; i++) begin
            slot_reg[i] <= slot_next[i];
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'b0000, slot_reg[0], tag_reg};
    assign m_tlast  = (rem_reg == 2'd0);

endmodule

`default_nettype wire
